// ===== sv/hamming_near_duplicate_grouper_defines.svh =====
// assertion macros for the near-duplicate grouper
`ifndef HAMMING_NEAR_DUPLICATE_GROUPER_DEFINES_SVH
`define HAMMING_NEAR_DUPLICATE_GROUPER_DEFINES_SVH

// implication checked on every clock edge out of reset
`define HNDG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hndg check failed");

// next-cycle implication checked out of reset
`define HNDG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hndg check failed");

`endif

// ===== sv/hndg_pkg.sv =====
// shared types and constants of the near-duplicate grouper
`default_nettype none
package hndg_pkg;
  localparam int MaxImagesDefault = 64;
  localparam int IdxW = 6;
  localparam int GrpW = 5;
  localparam int TagW = 6;
  localparam int HashW = 64;
  localparam int LimW = 7;
  localparam int CntW = 7;
  localparam int GroupMin = 2;
  localparam logic [LimW-1:0] LimitReset = 7'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic store;       // write input beat at count
    logic clr_count;   // restart batch
    logic set_i;       // pointer loads
    logic set_j;
    logic inc_i;
    logic inc_j;
    logic rd_pair;     // read hash/tag of i and j
    logic pair_eval;   // register distance result
    logic ld_x;        // load walker from i or j
    logic x_from_j;
    logic rd_x;        // read parent of x
    logic rd_p;        // read parent of parent
    logic halve;       // parent[x] <= parent[p], x <= that
    logic save_ra;
    logic link;        // parent[ra] <= x
    logic clr_size;    // clear size counter at i
    logic root_save;   // root_of[i] <= x, read size[x]
    logic size_inc;    // size[x] <= read size + 1
    logic rd_size;     // read size[i]
    logic label;       // label[i] <= groups, groups++
    logic rd_emit;     // read root_of[j]
    logic rd_lab;      // read label[i]
    logic clr_groups;
  } hndg_cmd_t;

  typedef struct packed {
    logic             full;
    logic             i_end;   // i + 1 >= n
    logic             j_end;   // j + 1 >= n
    logic             join_ok;
    logic             x_is_root;
    logic             same_root;
    logic             big;
    logic             emit_hit;
  } hndg_sts_t;
endpackage
`default_nettype wire

// ===== sv/hndg_datapath.sv =====
// datapath: stores, pair compare, union-find walker, grouping tables
`default_nettype none
module hndg_datapath #(
  parameter int MAX_IMAGES = hndg_pkg::MaxImagesDefault
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  hndg_pkg::hndg_cmd_t          cmd,
  output hndg_pkg::hndg_sts_t          sts,
  input  wire [hndg_pkg::HashW-1:0]    in_image_hash,
  input  wire [hndg_pkg::TagW-1:0]     in_exact_tag,
  input  wire [hndg_pkg::LimW-1:0]     limit,
  output logic [hndg_pkg::IdxW-1:0]    res_index,
  output logic [hndg_pkg::GrpW-1:0]    res_group
);
  import hndg_pkg::*;

  localparam int NumBytes = HashW / 8;

  logic [HashW-1:0] hash_mem [MAX_IMAGES];
  logic [TagW-1:0]  tag_mem  [MAX_IMAGES];
  logic [IdxW-1:0]  par_mem  [MAX_IMAGES];
  logic [IdxW-1:0]  root_mem [MAX_IMAGES];
  logic [CntW-1:0]  size_mem [MAX_IMAGES];
  logic [IdxW-1:0]  lab_mem  [MAX_IMAGES];

  logic [CntW-1:0]  cnt_r;
  logic [IdxW-1:0]  i_r, j_r, x_r, p_r, px_r, pp_r, ra_r;
  logic [HashW-1:0] hi_r, hj_r;
  logic [TagW-1:0]  ti_r, tj_r;
  logic             skip_r;
  logic [3:0]       bc [NumBytes];
  logic [3:0]       bc_r [NumBytes];
  logic [CntW-1:0]  sz_r;
  logic [IdxW-1:0]  rj_r;
  logic [GrpW-1:0]  grp_r, lab_r;
  logic [6:0]       pc;
  logic [CntW-1:0]  i_ext, j_ext;

  // per-byte bit counts, registered, then summed
  always_comb begin
    for (int k = 0; k < NumBytes; k++) begin
      bc[k] = '0;
      for (int b = 0; b < 8; b++) bc[k] = bc[k] + 4'((hi_r[8*k+b] ^ hj_r[8*k+b]));
    end
  end

  always_comb begin
    pc = '0;
    for (int k = 0; k < NumBytes; k++) pc = pc + 7'(bc_r[k]);
  end

  assign i_ext = {1'b0, i_r};
  assign j_ext = {1'b0, j_r};

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      hash_mem[cnt_r[IdxW-1:0]] <= in_image_hash;
      tag_mem[cnt_r[IdxW-1:0]]  <= in_exact_tag;
      par_mem[cnt_r[IdxW-1:0]]  <= cnt_r[IdxW-1:0];
    end else if (cmd.halve) begin
      par_mem[x_r] <= pp_r;
    end else if (cmd.link) begin
      par_mem[ra_r] <= x_r;
    end
    if (cmd.rd_pair) begin
      hi_r <= hash_mem[i_r];
      hj_r <= hash_mem[j_r];
      ti_r <= tag_mem[i_r];
      tj_r <= tag_mem[j_r];
    end
    if (cmd.rd_x) px_r <= par_mem[x_r];
    if (cmd.rd_p) pp_r <= par_mem[p_r];
    if (cmd.clr_size) size_mem[i_r] <= '0;
    else if (cmd.size_inc) size_mem[x_r] <= sz_r + 1'b1;
    if (cmd.root_save) root_mem[i_r] <= x_r;
    if (cmd.rd_size) sz_r <= size_mem[i_r];
    else if (cmd.root_save) sz_r <= size_mem[x_r];
    if (cmd.label) lab_mem[i_r] <= {1'b0, grp_r};
    if (cmd.rd_emit) rj_r <= root_mem[j_r];
    if (cmd.rd_lab) lab_r <= lab_mem[i_r][GrpW-1:0];
    if (cmd.pair_eval) begin
      skip_r <= (ti_r != '0 && ti_r == tj_r);
      for (int k = 0; k < NumBytes; k++) bc_r[k] <= bc[k];
    end
    if (cmd.ld_x) x_r <= cmd.x_from_j ? j_r : i_r;
    else if (cmd.halve) x_r <= pp_r;
    if (cmd.rd_x) p_r <= par_mem[x_r];
    if (cmd.save_ra) ra_r <= x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      i_r <= '0;
      j_r <= '0;
      grp_r <= '0;
    end else begin
      if (cmd.clr_count) cnt_r <= '0;
      else if (cmd.store) cnt_r <= cnt_r + 1'b1;
      if (cmd.set_i) i_r <= '0;
      else if (cmd.inc_i) i_r <= i_r + 1'b1;
      if (cmd.set_j) j_r <= cmd.inc_i ? '0 : IdxW'(i_r + 1'b1);
      else if (cmd.inc_j) j_r <= j_r + 1'b1;
      if (cmd.clr_groups) grp_r <= '0;
      else if (cmd.label) grp_r <= grp_r + 1'b1;
    end
  end

  assign sts.full      = (cnt_r >= CntW'(MAX_IMAGES));
  assign sts.i_end     = (i_ext + 1'b1 >= cnt_r);
  assign sts.j_end     = (j_ext + 1'b1 >= cnt_r);
  assign sts.join_ok   = !skip_r && (pc <= limit);
  assign sts.x_is_root = (px_r == x_r);
  assign sts.same_root = (ra_r == x_r);
  assign sts.big       = (sz_r >= CntW'(GroupMin));
  assign sts.emit_hit  = (rj_r == i_r);
  assign res_index     = j_r;
  assign res_group     = lab_r;
endmodule
`default_nettype wire

// ===== sv/hndg_ctrl.sv =====
// controller: load, pair sweep, find/unite, count, label, emit
`default_nettype none
module hndg_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_last_image,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_is_member,
  output logic                  out_last_result,
  output logic                  emit_load,
  output hndg_pkg::hndg_cmd_t   cmd,
  input  hndg_pkg::hndg_sts_t   sts
);
  import hndg_pkg::*;

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_PRD    = 5'd1;
  localparam logic [4:0] S_PEV    = 5'd2;
  localparam logic [4:0] S_PDEC   = 5'd3;
  localparam logic [4:0] S_FRX    = 5'd4;
  localparam logic [4:0] S_FRP    = 5'd5;
  localparam logic [4:0] S_FCHK   = 5'd6;
  localparam logic [4:0] S_FB     = 5'd7;
  localparam logic [4:0] S_LINK   = 5'd8;
  localparam logic [4:0] S_PNXT   = 5'd9;
  localparam logic [4:0] S_CLR    = 5'd10;
  localparam logic [4:0] S_RFX    = 5'd11;
  localparam logic [4:0] S_RFP    = 5'd12;
  localparam logic [4:0] S_RCHK   = 5'd13;
  localparam logic [4:0] S_LRD    = 5'd14;
  localparam logic [4:0] S_LCHK   = 5'd15;
  localparam logic [4:0] S_ERD    = 5'd16;
  localparam logic [4:0] S_ECHK   = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;
  localparam logic [4:0] S_NONE   = 5'd19;
  localparam logic [4:0] S_FLUSH  = 5'd20;
  localparam logic [4:0] S_ENXT   = 5'd21;
  localparam logic [4:0] S_ELAB   = 5'd22;
  localparam logic [4:0] S_RINC   = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic       second_r, second_nxt;   // finding root of j
  logic       pend_r, pend_nxt;       // a member result waits in hold
  logic       ov_r, ov_nxt, lr_r, lr_nxt, mem_r, mem_nxt;
  logic       out_fire;

  assign out_fire        = out_valid && out_ready;
  assign out_valid       = ov_r;
  assign out_is_member   = mem_r;
  assign out_last_result = lr_r;
  assign in_ready        = (state_r == S_LOAD);

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    pend_nxt   = pend_r;
    ov_nxt     = ov_r && !out_fire;
    lr_nxt     = lr_r;
    mem_nxt    = mem_r;
    emit_load  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store = !sts.full;
          if (in_last_image) begin
            cmd.set_i = 1'b1;
            state_nxt = S_PNXT;
          end
        end
      end
      S_PNXT: begin
        // new row: j starts at i + 1
        cmd.set_j = 1'b1;
        if (sts.i_end) begin
          cmd.set_i = 1'b1;
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        cmd.rd_pair = 1'b1;
        state_nxt = S_PEV;
      end
      S_PEV: begin
        cmd.pair_eval = 1'b1;
        state_nxt = S_PDEC;
      end
      S_PDEC: begin
        if (sts.join_ok) begin
          cmd.ld_x = 1'b1;
          second_nxt = 1'b0;
          state_nxt = S_FRX;
        end else begin
          state_nxt = S_FB;
        end
      end
      S_FRX: begin
        cmd.rd_x = 1'b1;
        state_nxt = S_FRP;
      end
      S_FRP: begin
        cmd.rd_p = 1'b1;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (sts.x_is_root) begin
          if (!second_r) begin
            cmd.save_ra = 1'b1;
            cmd.ld_x = 1'b1;
            cmd.x_from_j = 1'b1;
            second_nxt = 1'b1;
            state_nxt = S_FRX;
          end else begin
            state_nxt = S_LINK;
          end
        end else begin
          cmd.halve = 1'b1;
          state_nxt = S_FRX;
        end
      end
      S_LINK: begin
        cmd.link = !sts.same_root;
        state_nxt = S_FB;
      end
      S_FB: begin
        // advance pair pointers
        if (sts.j_end) begin
          cmd.inc_i = 1'b1;
          state_nxt = S_PNXT;
        end else begin
          cmd.inc_j = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_CLR: begin
        cmd.clr_size = 1'b1;
        if (sts.i_end) begin
          cmd.set_i = 1'b1;
          state_nxt = S_ELAB;
        end else begin
          cmd.inc_i = 1'b1;
        end
      end
      S_ELAB: begin
        cmd.ld_x = 1'b1;
        state_nxt = S_RFX;
      end
      S_RFX: begin
        cmd.rd_x = 1'b1;
        state_nxt = S_RFP;
      end
      S_RFP: begin
        cmd.rd_p = 1'b1;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (sts.x_is_root) begin
          cmd.root_save = 1'b1;
          state_nxt = S_RINC;
        end else begin
          cmd.halve = 1'b1;
          state_nxt = S_RFX;
        end
      end
      S_RINC: begin
        cmd.size_inc = 1'b1;
        if (sts.i_end) begin
          cmd.set_i = 1'b1;
          cmd.clr_groups = 1'b1;
          state_nxt = S_LRD;
        end else begin
          cmd.inc_i = 1'b1;
          state_nxt = S_ELAB;
        end
      end
      S_LRD: begin
        cmd.rd_size = 1'b1;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        cmd.label = sts.big;
        if (sts.i_end) begin
          cmd.set_i = 1'b1;
          cmd.set_j = 1'b1;
          cmd.inc_i = 1'b1;
          pend_nxt = 1'b0;
          state_nxt = S_ERD;
        end else begin
          cmd.inc_i = 1'b1;
          state_nxt = S_LRD;
        end
      end
      S_ERD: begin
        // scan root i, j from 0; set_j with inc_i zeroes j
        cmd.rd_size = 1'b1;
        cmd.rd_emit = 1'b1;
        cmd.rd_lab = 1'b1;
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        if (sts.big && sts.emit_hit) begin
          if (!pend_r) begin
            emit_load = 1'b1;
            pend_nxt = 1'b1;
            state_nxt = S_ENXT;
          end else if (!ov_r || out_fire) begin
            ov_nxt = 1'b1;
            lr_nxt = 1'b0;
            mem_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_ENXT;
        end
      end
      S_OUT: begin
        // hold just shown; capture current member into hold
        emit_load = 1'b1;
        state_nxt = S_ENXT;
      end
      S_ENXT: begin
        if (sts.j_end) begin
          if (sts.i_end) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.inc_i = 1'b1;
            cmd.set_j = 1'b1;
            state_nxt = S_ERD;
          end
        end else begin
          cmd.inc_j = 1'b1;
          state_nxt = S_ERD;
        end
      end
      S_FLUSH: begin
        if (!ov_r || out_fire) begin
          ov_nxt = 1'b1;
          lr_nxt = 1'b1;
          mem_nxt = pend_r;
          emit_load = !pend_r;
          cmd.clr_count = 1'b1;
          state_nxt = S_NONE;
        end
      end
      S_NONE: begin
        if (!ov_r || out_fire) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      second_r <= 1'b0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
      lr_r     <= 1'b0;
      mem_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
      lr_r     <= lr_nxt;
      mem_r    <= mem_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/hamming_near_duplicate_grouper.sv =====
// top level of the hamming near-duplicate grouper
// Input channel in_*: one beat per image (hash, exact tag, last flag), taken
// one per cycle while the batch loads. The beat with in_last_image closes
// the batch; beats past MAX_IMAGES are dropped but still end it.
// After the last beat the block sweeps the n*(n-1)/2 pairs i<j; a joining
// pair runs a path-halving find on i and j and links the two roots. Roots
// are then resolved per image and groups labeled. The emit scan visits n*n
// root/image slots and shows each member that it finds.
// Output channel out_*: one beat per grouped image, groups in ascending root
// order; out_last_result marks the final beat. With no group a single beat
// with out_is_member low is sent. The next member waits in a hold register
// while a beat is shown, and the scan stalls while the receiver stalls.
// in_ready is low until the final beat is taken. Reset (rst_n low,
// synchronous) empties the batch and sets the distance limit to 5; the user
// writes cfg_distance_limit only while idle, the block does not enforce it.
`default_nettype none
`include "hamming_near_duplicate_grouper_defines.svh"
module hamming_near_duplicate_grouper #(
  parameter int MAX_IMAGES = hndg_pkg::MaxImagesDefault
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [hndg_pkg::HashW-1:0]    in_image_hash,
  input  wire [hndg_pkg::TagW-1:0]     in_exact_tag,
  input  wire                          in_last_image,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hndg_pkg::IdxW-1:0]    out_image_index,
  output logic [hndg_pkg::GrpW-1:0]    out_group_number,
  output logic                         out_is_member,
  output logic                         out_last_result,
  input  wire                          cfg_we,
  input  wire [hndg_pkg::LimW-1:0]     cfg_distance_limit
);
  import hndg_pkg::*;

  hndg_cmd_t         cmd;
  hndg_sts_t         sts;
  logic [LimW-1:0]   limit_r;
  logic              emit_load;
  logic [IdxW-1:0]   res_index, hold_idx_r;
  logic [GrpW-1:0]   res_group, hold_grp_r;
  logic              ctl_mem;
  logic [IdxW-1:0]   oi_r;
  logic [GrpW-1:0]   og_r;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LimitReset;
    else if (cfg_we) limit_r <= cfg_distance_limit;
  end

  // hold: latest found member; emit_load in flush with no member zeroes it
  always_ff @(posedge clk) begin
    if (emit_load) begin
      hold_idx_r <= ctl_mem ? res_index : '0;
      hold_grp_r <= ctl_mem ? res_group : '0;
    end
  end

  // output register follows hold until a beat is shown
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      oi_r <= hold_idx_r;
      og_r <= hold_grp_r;
    end
  end

  assign ctl_mem = !(cmd.clr_count);

  hndg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_last_image(in_last_image),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_is_member(out_is_member), .out_last_result(out_last_result),
    .emit_load(emit_load), .cmd(cmd), .sts(sts)
  );

  hndg_datapath #(.MAX_IMAGES(MAX_IMAGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_image_hash(in_image_hash), .in_exact_tag(in_exact_tag),
    .limit(limit_r), .res_index(res_index), .res_group(res_group)
  );

  assign out_image_index  = out_is_member ? oi_r : '0;
  assign out_group_number = out_is_member ? og_r : '0;

  `HNDG_ASSERT_IMP(a_no_in_while_out, out_valid, !in_ready)
  `HNDG_ASSERT_NXT(a_last_then_idle, out_valid && out_ready && out_last_result, !out_valid)
  `HNDG_ASSERT_IMP(a_marker_is_last, out_valid && !out_is_member, out_last_result)
endmodule
`default_nettype wire

// ===== sim/tb_hamming_near_duplicate_grouper.sv =====
// testbench for the hamming near-duplicate grouper: batch stimulus, union-find prediction, checks
`timescale 1ns / 100ps
`default_nettype none
module tb_hamming_near_duplicate_grouper;
  import hndg_pkg::*;

  localparam int NumImages = 64;
  localparam longint CycleLimit = 64'd10000000;

  typedef struct packed {
    logic [IdxW-1:0] image_index;
    logic [GrpW-1:0] group_number;
    logic            is_member;
    logic            last_result;
  } group_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire in_ready;
  logic [HashW-1:0] in_image_hash = '0;
  logic [TagW-1:0] in_exact_tag = '0;
  logic in_last_image = 1'b0;
  wire out_valid;
  logic out_ready = 1'b0;
  wire [IdxW-1:0] out_image_index;
  wire [GrpW-1:0] out_group_number;
  wire out_is_member;
  wire out_last_result;
  logic cfg_we = 1'b0;
  logic [LimW-1:0] cfg_distance_limit = '0;

  hamming_near_duplicate_grouper #(.MAX_IMAGES(NumImages)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_image_hash(in_image_hash),
    .in_exact_tag(in_exact_tag), .in_last_image(in_last_image),
    .out_valid(out_valid), .out_ready(out_ready), .out_image_index(out_image_index),
    .out_group_number(out_group_number), .out_is_member(out_is_member),
    .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_distance_limit(cfg_distance_limit)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [HashW-1:0] batch_hash [NumImages];
  logic [TagW-1:0]  batch_tag [NumImages];
  int unsigned      batch_parent [NumImages];
  int unsigned      batch_count = 0;
  logic [LimW-1:0]  join_limit = LimitReset;
  group_beat_t      pending_groups [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatch_count = 0;
  longint cycle_count = 0;

  function automatic int unsigned root_of_image(int unsigned x);
    int unsigned p;
    while (batch_parent[x] != x) begin
      p = batch_parent[x];
      batch_parent[x] = batch_parent[p];
      x = batch_parent[x];
    end
    return x;
  endfunction

  task automatic predict_groups();
    int unsigned roots [NumImages];
    int unsigned sizes [NumImages];
    int unsigned labels [NumImages];
    int unsigned n, ra, rb, groups;
    group_beat_t b;
    int beats;
    n = batch_count;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (batch_tag[i] != 0 && batch_tag[i] == batch_tag[j]) continue;
        if ($countones(batch_hash[i] ^ batch_hash[j]) <= join_limit) begin
          ra = root_of_image(i);
          rb = root_of_image(j);
          if (ra != rb) batch_parent[ra] = rb;
        end
      end
    end
    for (int i = 0; i < NumImages; i++) sizes[i] = 0;
    for (int i = 0; i < n; i++) begin
      roots[i] = root_of_image(i);
      sizes[roots[i]]++;
    end
    groups = 0;
    for (int i = 0; i < n; i++) begin
      if (sizes[i] >= GroupMin) begin
        labels[i] = groups;
        groups++;
      end
    end
    beats = 0;
    for (int i = 0; i < n; i++) begin
      if (sizes[i] < GroupMin) continue;
      for (int j = 0; j < n; j++) begin
        if (roots[j] == i) begin
          b.image_index = j[IdxW-1:0];
          b.group_number = labels[i][GrpW-1:0];
          b.is_member = 1'b1;
          b.last_result = 1'b0;
          pending_groups = {pending_groups, b};
          beats++;
        end
      end
    end
    if (beats == 0) begin
      b = '0;
      b.last_result = 1'b1;
      pending_groups = {pending_groups, b};
    end else begin
      pending_groups[$].last_result = 1'b1;
    end
    batch_count = 0;
  endtask

  task automatic send_image(input logic [HashW-1:0] h, input logic [TagW-1:0] t,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_image_hash <= h;
    in_exact_tag <= t;
    in_last_image <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (batch_count < NumImages) begin
      batch_hash[batch_count] = h;
      batch_tag[batch_count] = t;
      batch_parent[batch_count] = batch_count;
      batch_count++;
    end
    if (last) predict_groups();
    @(negedge clk);
    if (last) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain_and_wait();
    while (pending_groups.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LimW-1:0] v);
    drain_and_wait();
    cfg_we <= 1'b1;
    cfg_distance_limit <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    join_limit = v;
  endtask

  // flip a few random bits of a base hash
  function automatic logic [HashW-1:0] near_hash(logic [HashW-1:0] base, int flips);
    for (int k = 0; k < flips; k++) base[$urandom_range(HashW - 1)] ^= 1'b1;
    return base;
  endfunction

  task automatic send_batch(int n, int family);
    logic [HashW-1:0] seeds [4];
    logic [HashW-1:0] h;
    logic [TagW-1:0] t;
    for (int s = 0; s < 4; s++) seeds[s] = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      if (family != 0 && $urandom_range(9) < 8)
        h = near_hash(seeds[$urandom_range(family - 1)], $urandom_range(8));
      else
        h = {$urandom, $urandom};
      t = ($urandom_range(3) == 0) ? TagW'($urandom_range(3)) : '0;
      send_image(h, t, i == n - 1);
    end
  endtask

  task automatic test_directed();
    send_image('0, '0, 1'b1);
    send_image('0, '0, 1'b0);
    send_image('1, 6'h3f, 1'b1);
    send_image(64'h0, 6'd1, 1'b0);
    send_image(64'h1, 6'd1, 1'b0);
    send_image(64'h3, 6'd0, 1'b0);
    send_image('1, 6'h3f, 1'b0);
    send_image(64'hffff_ffff_ffff_fffe, 6'h3f, 1'b0);
    send_image(64'h7fff_ffff_ffff_fffe, 6'd2, 1'b1);
  endtask

  task automatic test_full_batch();
    // seventy beats: the surplus is dropped, last still ends the batch
    for (int i = 0; i < 70; i++)
      send_image(near_hash(64'h5a5a_a5a5_0ff0_f00f, $urandom_range(12)),
                 TagW'($urandom_range(63)), i == 69);
  endtask

  task automatic test_limits();
    write_limit('0);
    send_batch(6, 1);
    send_image(64'h1234, '0, 1'b0);
    send_image(64'h1234, '0, 1'b1);
    write_limit(7'd64);
    send_batch(5, 0);
    write_limit(7'd127);
    send_batch(5, 0);
    write_limit(7'd5);
  endtask

  task automatic test_random(int total);
    int sent;
    int n;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(9) == 0) write_limit(LimW'($urandom_range(127)));
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 2) : $urandom_range(12, 1);
      send_batch(n, $urandom_range(4));
      sent += n;
    end
  endtask

  // receiver
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    group_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_groups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat idx=%0d", out_image_index);
      end else begin
        want = pending_groups.pop_front();
        if (want.image_index !== out_image_index || want.group_number !== out_group_number ||
            want.is_member !== out_is_member || want.last_result !== out_last_result) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp idx=%0d grp=%0d mem=%0b last=%0b got %0d %0d %0b %0b",
                     want.image_index, want.group_number, want.is_member,
                     want.last_result, out_image_index, out_group_number,
                     out_is_member, out_last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 79;
    test_directed();
    test_full_batch();
    test_limits();
    test_random(60);
    send_idle_pct = 79;
    recv_idle_pct = 12;
    test_random(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60);
    drain_and_wait();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
